FILE: hw/rtl/hsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg
// Types and constants shared by the hostname syntax checker.
// ----------------------------------------------------------------------------
package hsc_pkg;

    // field widths
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned LABEL_W     = 8;
    localparam int unsigned HOST_CFG_W  = 10;
    localparam int unsigned HOST_LEN_W  = 11;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam int unsigned OUT_DATA_W  = 16;

    // saturation limits
    localparam logic [LABEL_W-1:0]    LABEL_SAT = 8'd255;
    localparam logic [HOST_LEN_W-1:0] HOST_SAT  = 11'd1024;

    // special characters
    localparam logic [CHAR_W-1:0] CHAR_TERM       = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOT        = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_HYPHEN     = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LABEL_LEN = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_HOST_LEN  = 8'd1;

    // reset values of the limits
    localparam logic [LABEL_W-1:0]    MAX_LABEL_RST = 8'd63;
    localparam logic [HOST_CFG_W-1:0] MAX_HOST_RST  = 10'd255;

    // kind of the previous character
    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_DOT    = 2'd1,
        KIND_HYPHEN = 2'd2
    } kind_t;

endpackage

FILE: hw/rtl/hostname_syntax_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hostname_syntax_checker
// Checks DNS hostname syntax on a byte stream, one verdict per zero byte.
// ----------------------------------------------------------------------------
// Path: an accepted terminator byte passes the input register, then the result
// register, which holds its verdict.
// Throughput: 1 byte per cycle; other bytes keep flowing while a verdict waits,
// a terminator holds in the input register until the waiting verdict is taken.
// Reset: rst_n clears all name state and sets the limits to 63 and 255.
module hostname_syntax_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hsc_pkg::CHAR_W-1:0]        s_axis_tdata,   // [7:0] char_code
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [0] name_ok,
                                                              // [11:1] name_length,
                                                              // [15:12] zero
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration registers
    logic [hsc_pkg::LABEL_W-1:0]    max_label_reg;
    logic [hsc_pkg::HOST_CFG_W-1:0] max_host_reg;

    // input register
    logic                        in_vld_reg;
    logic [hsc_pkg::CHAR_W-1:0]  in_char_reg;

    // per-name state
    logic [hsc_pkg::LABEL_W-1:0]    label_len_reg, label_len_next;
    logic [hsc_pkg::HOST_LEN_W-1:0] host_len_reg, host_len_next;
    logic                           bad_seen_reg, bad_seen_next;
    hsc_pkg::kind_t                 prev_kind_reg, prev_kind_next;

    // result register
    logic                           out_vld_reg;
    logic                           out_ok_reg, out_ok_next;
    logic [hsc_pkg::HOST_LEN_W-1:0] out_len_reg;

    logic is_term;
    logic is_word;
    logic out_free;
    logic proc_en;
    logic [hsc_pkg::LABEL_W:0]      label_inc;
    logic [hsc_pkg::LABEL_W-1:0]    label_sat;

    assign cfg_ready = 1'b1;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_label_reg <= hsc_pkg::MAX_LABEL_RST;
            max_host_reg  <= hsc_pkg::MAX_HOST_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hsc_pkg::CFG_MAX_LABEL_LEN: max_label_reg <= cfg_data[hsc_pkg::LABEL_W-1:0];
                hsc_pkg::CFG_MAX_HOST_LEN:  max_host_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: a terminator needs a free result slot, other bytes never stall
    assign is_term       = (in_char_reg == hsc_pkg::CHAR_TERM);
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign proc_en       = in_vld_reg && (!is_term || out_free);
    assign s_axis_tready = !in_vld_reg || proc_en;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
        end
    end

    // character class
    always_comb
    begin
        is_word = (in_char_reg inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]})
                  || (in_char_reg == hsc_pkg::CHAR_UNDERSCORE);
    end

    // label length plus one at full precision, and its saturated form
    assign label_inc = {1'b0, label_len_reg} + 9'd1;
    assign label_sat = label_inc[hsc_pkg::LABEL_W] ? hsc_pkg::LABEL_SAT
                                                   : label_inc[hsc_pkg::LABEL_W-1:0];

    // next name state and verdict
    always_comb
    begin
        label_len_next = label_len_reg;
        host_len_next  = host_len_reg;
        bad_seen_next  = bad_seen_reg;
        prev_kind_next = prev_kind_reg;
        out_ok_next    = !bad_seen_reg;

        if (is_term)
        begin
            if (host_len_reg == '0)
                out_ok_next = 1'b0;
            if (prev_kind_reg == hsc_pkg::KIND_DOT || prev_kind_reg == hsc_pkg::KIND_HYPHEN)
                out_ok_next = 1'b0;
            if (host_len_reg > {1'b0, max_host_reg})
                out_ok_next = 1'b0;
            label_len_next = '0;
            host_len_next  = '0;
            bad_seen_next  = 1'b0;
            prev_kind_next = hsc_pkg::KIND_OTHER;
        end
        else
        begin
            if (host_len_reg < hsc_pkg::HOST_SAT)
                host_len_next = host_len_reg + 11'd1;

            if (is_word)
            begin
                if (label_inc > {1'b0, max_label_reg})
                    bad_seen_next = 1'b1;
                label_len_next = label_sat;
                prev_kind_next = hsc_pkg::KIND_OTHER;
            end
            else if (in_char_reg == hsc_pkg::CHAR_DOT)
            begin
                if (label_len_reg == '0 || prev_kind_reg == hsc_pkg::KIND_HYPHEN)
                    bad_seen_next = 1'b1;
                label_len_next = '0;
                prev_kind_next = hsc_pkg::KIND_DOT;
            end
            else if (in_char_reg == hsc_pkg::CHAR_HYPHEN)
            begin
                if (label_len_reg == '0)
                    bad_seen_next = 1'b1;
                label_len_next = label_sat;
                prev_kind_next = hsc_pkg::KIND_HYPHEN;
            end
            else
            begin
                bad_seen_next  = 1'b1;
                prev_kind_next = hsc_pkg::KIND_OTHER;
            end
        end
    end

    // name state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_len_reg <= '0;
            host_len_reg  <= '0;
            bad_seen_reg  <= 1'b0;
            prev_kind_reg <= hsc_pkg::KIND_OTHER;
        end
        else if (proc_en)
        begin
            label_len_reg <= label_len_next;
            host_len_reg  <= host_len_next;
            bad_seen_reg  <= bad_seen_next;
            prev_kind_reg <= prev_kind_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= proc_en && is_term;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en && is_term)
        begin
            out_ok_reg  <= out_ok_next;
            out_len_reg <= host_len_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'd0, out_len_reg, out_ok_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a processed terminator leaves a clean name state
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc_en && is_term) |=> (host_len_reg == '0 && label_len_reg == '0 && !bad_seen_reg))
    else $error("name state not cleared after terminator");

    // the byte counter never passes its saturation point
    assert property (@(posedge clk) disable iff (!rst_n)
        host_len_reg <= hsc_pkg::HOST_SAT)
    else $error("host length counter beyond saturation");

    // a valid verdict never belongs to an empty name
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_ok_reg) |-> (out_len_reg != '0))
    else $error("empty name reported valid");

    // with the result slot empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_axis_tready)
    else $error("input stalled with empty result register");

    // a terminator processed while a verdict is held must see it drained
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc_en && is_term && out_vld_reg) |-> m_axis_tready)
    else $error("verdict overwritten before it was taken");

endmodule
